// ===== rtl/core/rsa_pkg.sv =====
// Shared types, constants and section tables for the relay step attenuator.
// No dependencies; every module of the block imports it.
package rsa_pkg;

  localparam int NUM_RELAYS   = 7;
  localparam int IDX_W        = 3;
  localparam int NUM_SECTIONS = 5;
  localparam int ALU_W        = 16;

  // Relay numbering on the coil driver
  localparam logic [IDX_W-1:0] RELAY_40A  = 3'd0;
  localparam logic [IDX_W-1:0] RELAY_20A  = 3'd1;
  localparam logic [IDX_W-1:0] RELAY_1DB  = 3'd2;
  localparam logic [IDX_W-1:0] RELAY_20B  = 3'd3;
  localparam logic [IDX_W-1:0] RELAY_10DB = 3'd4;
  localparam logic [IDX_W-1:0] RELAY_40B  = 3'd5;
  localparam logic [IDX_W-1:0] RELAY_RF   = 3'd6;

  // Configuration register indexes (address bit 2)
  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_MAX_ATTEN = 1'b1;

  localparam logic [7:0] STEP_SIZE_RST = 8'd1;
  localparam logic [7:0] MAX_ATTEN_RST = 8'd131;

  typedef logic [NUM_RELAYS-1:0] relay_vec_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             ge;
  } alu_res_t;

  typedef struct packed {
    logic       start;
    relay_vec_t diff;
    relay_vec_t want;
  } emit_cmd_t;

  // Greedy split order: 40A, 40B, 20A, 20B, 10
  function automatic logic [5:0] sec_size(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd0, 3'd1: s = 6'd40;
      3'd2, 3'd3: s = 6'd20;
      3'd4:       s = 6'd10;
      default:    s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic [IDX_W-1:0] sec_relay(input logic [2:0] k);
    logic [IDX_W-1:0] r;
    case (k)
      3'd0:    r = RELAY_40A;
      3'd1:    r = RELAY_40B;
      3'd2:    r = RELAY_20A;
      3'd3:    r = RELAY_20B;
      3'd4:    r = RELAY_10DB;
      default: r = RELAY_RF;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/rsa_alu.sv =====
// Shared compare-subtract unit: a - b with an a >= b flag.
// Depends on rsa_pkg for the operand and result types.
module rsa_alu (
  input  rsa_pkg::alu_op_t  op,
  output rsa_pkg::alu_res_t res
);
  import rsa_pkg::*;

  logic [ALU_W:0] sub;

  assign sub      = {1'b0, op.a} - {1'b0, op.b};
  assign res.diff = sub[ALU_W-1:0];
  assign res.ge   = ~sub[ALU_W];

endmodule

// ===== rtl/core/rsa_emit.sv =====
// Pulse command emitter: walks the changed-relay mask one relay per cycle
// unless stalled, and drives the registered result channel. Needs rsa_pkg.
module rsa_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsa_pkg::emit_cmd_t          cmd,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsa_pkg::IDX_W-1:0]   out_relay_index,
  output logic                        out_coil_on,
  output logic                        out_last
);
  import rsa_pkg::*;

  logic             busy_r, busy_nxt;
  relay_vec_t       pend_r, pend_nxt;
  relay_vec_t       want_r, want_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_coil_r, out_coil_nxt;
  logic             out_last_r, out_last_nxt;
  relay_vec_t       cur_bit;
  relay_vec_t       pend_left;
  logic             load_ok;

  assign cur_bit   = relay_vec_t'(1) << idx_r;
  assign pend_left = pend_r & ~cur_bit;
  assign load_ok   = ~out_valid_r | out_ready;

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    want_nxt      = want_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_idx_nxt   = out_idx_r;
    out_coil_nxt  = out_coil_r;
    out_last_nxt  = out_last_r;
    if (cmd.start) begin
      pend_nxt = cmd.diff;
      want_nxt = cmd.want;
      idx_nxt  = '0;
      busy_nxt = |cmd.diff;
    end else if (busy_r) begin
      if (pend_r[idx_r]) begin
        // hold until the output register is free
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_coil_nxt  = want_r[idx_r];
          out_last_nxt  = ~|pend_left;
          pend_nxt      = pend_left;
          idx_nxt       = idx_r + IDX_W'(1);
          busy_nxt      = |pend_left;
        end
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
    end
    want_r     <= want_nxt;
    out_idx_r  <= out_idx_nxt;
    out_coil_r <= out_coil_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_relay_index = out_idx_r;
  assign out_coil_on     = out_coil_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/relay_step_attenuator_control.sv =====
// Relay step attenuator control, top level: config registers, sequencer
// around one shared compare-subtract unit, and the pulse emitter.
// From request to first pulse command: 15 divide steps, subtract, clamp, 5 section
// steps, then the emitter scans the relays from 0 up to the first changed relay.
// A new request is taken only once the emitter is done (one relay per cycle, held on stalls).
// Synchronous active-low reset: registers to step 1 / max 131, all relays off.
module relay_step_attenuator_control (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_request_db,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsa_pkg::IDX_W-1:0]   out_relay_index,
  output logic                        out_coil_on,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rsa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ATT   = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_SPLIT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [14:0]      dvd_r, dvd_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [15:0]      work_r, work_nxt;
  relay_vec_t       want_r, want_nxt;
  logic             att_nz_r, att_nz_nxt;
  relay_vec_t       relay_state_r, relay_state_nxt;
  logic [7:0]       step_r, max_r;
  logic [7:0]       step_eff;
  logic             div_bit;
  relay_vec_t       want_fin;
  alu_op_t          alu_op;
  alu_res_t         alu_res;
  emit_cmd_t        emit_cmd;
  logic             emit_busy;
  logic             cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_SIZE_RST;
      max_r  <= MAX_ATTEN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_STEP_SIZE) begin
        step_r <= pwdata[7:0];
      end else begin
        max_r <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_ATTEN) ? {24'd0, max_r} : {24'd0, step_r};

  rsa_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign step_eff = (step_r == 8'd0) ? 8'd1 : step_r;
  assign div_bit  = dvd_r[cnt_r];
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    alu_op.a = '0;
    alu_op.b = '0;
    case (state_r)
      S_DIV: begin
        alu_op.a = {7'd0, rem_r, div_bit};
        alu_op.b = {8'd0, step_eff};
      end
      S_ATT: begin
        alu_op.a = {1'b0, dvd_r};
        alu_op.b = {8'd0, rem_r};
      end
      S_CLAMP: begin
        alu_op.a = {8'd0, max_r};
        alu_op.b = work_r;
      end
      S_SPLIT: begin
        alu_op.a = work_r;
        alu_op.b = {10'd0, sec_size(cnt_r[2:0])};
      end
      default: begin
        alu_op.a = '0;
        alu_op.b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    work_nxt        = work_r;
    want_nxt        = want_r;
    att_nz_nxt      = att_nz_r;
    relay_state_nxt = relay_state_r;
    want_fin        = '0;
    emit_cmd.start  = 1'b0;
    emit_cmd.diff   = '0;
    emit_cmd.want   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // negative requests are replaced by zero, so they quantize and clamp to zero
          dvd_nxt   = in_request_db[15] ? 15'd0 : in_request_db[14:0];
          rem_nxt   = '0;
          cnt_nxt   = 4'd14;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one dividend bit per cycle; only the remainder is kept
        rem_nxt = alu_res.ge ? alu_res.diff[7:0] : alu_op.a[7:0];
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = S_ATT;
        end
      end
      S_ATT: begin
        work_nxt  = alu_res.diff;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        work_nxt   = alu_res.ge ? work_r : {8'd0, max_r};
        att_nz_nxt = alu_res.ge ? (work_r != 16'd0) : (max_r != 8'd0);
        want_nxt   = '0;
        cnt_nxt    = '0;
        state_nxt  = S_SPLIT;
      end
      S_SPLIT: begin
        if (alu_res.ge) begin
          work_nxt = alu_res.diff;
          want_nxt[sec_relay(cnt_r[2:0])] = 1'b1;
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(NUM_SECTIONS - 1)) begin
          want_fin = want_nxt;
          want_fin[RELAY_1DB] = (work_nxt != 16'd0);
          want_fin[RELAY_RF]  = att_nz_r;
          emit_cmd.start  = 1'b1;
          emit_cmd.diff   = want_fin ^ relay_state_r;
          emit_cmd.want   = want_fin;
          relay_state_nxt = want_fin;
          state_nxt       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!emit_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      relay_state_r <= '0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      relay_state_r <= relay_state_nxt;
      cnt_r         <= cnt_nxt;
    end
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    work_r   <= work_nxt;
    want_r   <= want_nxt;
    att_nz_r <= att_nz_nxt;
  end

  rsa_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (emit_cmd),
    .busy            (emit_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_relay_index (out_relay_index),
    .out_coil_on     (out_coil_on),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/core/rsa_checker.sv =====
// Port-level checks for the relay step attenuator control, bound to the top.
// Depends on rsa_pkg and relay_step_attenuator_control.
module rsa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rsa_pkg::IDX_W-1:0] out_relay_index,
  input logic                      out_coil_on,
  input logic                      out_last
);
  import rsa_pkg::*;

  // a request keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // no relay number beyond the RF relay
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_relay_index <= RELAY_RF)
    else $error("relay index out of range");

  // a command just delivered is never re-sent for the same relay in the next beat
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last ##1 out_valid |->
      out_relay_index != $past(out_relay_index))
    else $error("pulse command repeated");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relay_index)
      && $stable(out_coil_on) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind relay_step_attenuator_control rsa_checker u_rsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_relay_index (out_relay_index),
  .out_coil_on     (out_coil_on),
  .out_last        (out_last)
);

// ===== tb/relay_step_attenuator_control_tb.sv =====
// Self-checking bench for the relay step attenuator control block.
// Needs rsa_pkg and relay_step_attenuator_control; drives requests, register writes,
// and checks every coil-pulse command against its own relay model.
`timescale 1ns / 1ps

module relay_step_attenuator_control_tb;
  import rsa_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] relay;
    logic             coil_on;
    logic             last;
  } pulse_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_SPARSE
  } ready_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [15:0]       in_request_db = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         out_relay_index;
  logic                     out_coil_on;
  logic                     out_last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // Model state and configuration
  logic [7:0]               step_cfg = STEP_SIZE_RST;
  logic [7:0]               max_cfg = MAX_ATTEN_RST;
  relay_vec_t               relay_model = '0;

  logic [15:0]              request_q[$];
  pulse_t                   pulse_q[$];
  int                       sent_total = 0;
  int                       taken_total = 0;
  int                       pulses_seen = 0;
  int                       settings_total = 0;
  int                       errors = 0;
  logic                     in_taken = 1'b0;

  int                       burst_left = 1;
  int                       gap_left = 0;
  ready_mode_t              ready_mode = READY_ALWAYS;
  int                       mode_left = 0;
  int                       ready_tick = 0;

  relay_step_attenuator_control u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_request_db   (in_request_db),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_relay_index (out_relay_index),
    .out_coil_on     (out_coil_on),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  // Quantize, clamp, split into sections, then queue one pulse per relay that flips
  function automatic void plan_relay_pulses(input logic signed [15:0] request);
    int         quantum;
    int         atten;
    int         rest;
    int         top;
    relay_vec_t want;
    relay_vec_t flips;
    pulse_t     p;
    quantum = (step_cfg == 8'd0) ? 1 : int'(step_cfg);
    atten = (int'(request) / quantum) * quantum;
    if (atten > int'(max_cfg)) atten = int'(max_cfg);
    if (atten < 0) atten = 0;
    rest = atten;
    want = '0;
    if (rest >= 40) begin
      want[RELAY_40A] = 1'b1;
      rest -= 40;
    end
    if (rest >= 40) begin
      want[RELAY_40B] = 1'b1;
      rest -= 40;
    end
    if (rest >= 20) begin
      want[RELAY_20A] = 1'b1;
      rest -= 20;
    end
    if (rest >= 20) begin
      want[RELAY_20B] = 1'b1;
      rest -= 20;
    end
    if (rest >= 10) begin
      want[RELAY_10DB] = 1'b1;
      rest -= 10;
    end
    // any remainder at all sets the 1 dB relay, however large
    want[RELAY_1DB] = (rest >= 1);
    want[RELAY_RF] = (atten > 0);
    flips = want ^ relay_model;
    top = -1;
    for (int i = 0; i < NUM_RELAYS; i++) if (flips[i]) top = i;
    for (int i = 0; i < NUM_RELAYS; i++) begin
      if (flips[i]) begin
        p.relay = IDX_W'(i);
        p.coil_on = want[i];
        p.last = (i == top);
        pulse_q.push_back(p);
      end
    end
    relay_model = want;
  endfunction

  // Request driver: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_request_db <= request_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, switching between patterns
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      ready_tick++;
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_MOSTLY: out_ready <= (ready_tick % 4 != 0);
        default:      out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check pulses first, then predict from the request taken at this edge
  always @(posedge clk) begin
    pulse_t got;
    pulse_t exp_p;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.relay = out_relay_index;
        got.coil_on = out_coil_on;
        got.last = out_last;
        pulses_seen++;
        if (pulse_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pulse: expected none, got relay %0d coil %0b last %0b",
                   $time, got.relay, got.coil_on, got.last);
        end else begin
          exp_p = pulse_q.pop_front();
          if (got !== exp_p) begin
            errors++;
            $display({"%0t: pulse mismatch: expected relay %0d coil %0b last %0b,",
                      " got relay %0d coil %0b last %0b"},
                     $time, exp_p.relay, exp_p.coil_on, exp_p.last,
                     got.relay, got.coil_on, got.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        plan_relay_pulses(in_request_db);
        taken_total++;
      end
    end
  end

  task automatic queue_request(input int value);
    request_q.push_back(value[15:0]);
    sent_total++;
  endtask

  // Hold until every request is taken and every pulse has arrived, then let
  // a request that flips nothing drain through the pipeline
  task automatic wait_idle();
    @(negedge clk);
    while (taken_total != sent_total || pulse_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [7:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[7:0] !== value) begin
      errors++;
      $display("%0t: register %0d read back: expected %0d, got %0d",
               $time, reg_idx, value, rd[7:0]);
    end
    if (reg_idx == REG_STEP_SIZE) step_cfg = value;
    else max_cfg = value;
  endtask

  function automatic int random_request(input int ceiling, input int prev);
    int r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r = $urandom_range(0, ceiling + 15);
      5:             r = $urandom_range(0, 65535);
      6:             r = -int'($urandom_range(1, 300));
      7:             r = prev;
      8:             r = 10 * $urandom_range(0, (ceiling + 10) / 10);
      default:       r = $urandom_range(0, 255);
    endcase
    return r;
  endfunction

  initial begin
    int step_list[10];
    int max_list[10];
    int prev;
    step_list = '{0, 7, 131, 1, 255, 1, 10, 3, 0, 0};
    max_list  = '{131, 100, 131, 255, 255, 0, 139, 200, 0, 0};
    step_list[8] = $urandom_range(0, 255);
    max_list[8]  = $urandom_range(0, 255);
    step_list[9] = $urandom_range(1, 12);
    max_list[9]  = $urandom_range(100, 255);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset settings: section edges, clamping, field extremes,
    // repeats that flip nothing
    queue_request(0);
    queue_request(1);
    queue_request(9);
    queue_request(10);
    queue_request(11);
    queue_request(19);
    queue_request(20);
    queue_request(39);
    queue_request(40);
    queue_request(41);
    queue_request(79);
    queue_request(80);
    queue_request(100);
    queue_request(120);
    queue_request(130);
    queue_request(131);
    queue_request(131);
    queue_request(132);
    queue_request(139);
    queue_request(32767);
    queue_request(-1);
    queue_request(-32768);
    queue_request(0);
    queue_request(0);
    queue_request(55);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(REG_STEP_SIZE, step_list[ph][7:0]);
      cfg_write(REG_MAX_ATTEN, max_list[ph][7:0]);
      settings_total++;
      queue_request(max_list[ph]);
      queue_request(max_list[ph] + 1);
      queue_request(0);
      prev = 0;
      for (int n = 0; n < 41; n++) begin
        prev = random_request(max_list[ph], prev);
        queue_request(prev);
      end
      wait_idle();
    end

    // Final drain, bounded so a lost pulse shows up as a leftover
    @(negedge clk);
    while (taken_total != sent_total) @(negedge clk);
    for (int c = 0; c < 500 && pulse_q.size() != 0; c++) @(negedge clk);
    repeat (40) @(negedge clk);
    if (pulse_q.size() != 0) begin
      errors++;
      $display("%0t: pulses outstanding: expected 0 left, got %0d left", $time, pulse_q.size());
    end

    $display("Run covered %0d requests and %0d pulse commands over %0d register settings",
             taken_total, pulses_seen, settings_total + 1);
    $display("Settings spanned step 0 to 255 and max 0 to 255, with back-pressure patterns");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d of %0d requests taken", taken_total, sent_total);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
